[hdl/tbgm_pkg.sv]
// Shared constants, types and geometry helpers for the touch grid mapper.
`timescale 1ns / 1ps

package tbgm_pkg;

    typedef enum logic [1:0] {
        ALG_LEGACY   = 2'd0,
        ALG_IMPROVED = 2'd1,
        ALG_PLUS     = 2'd2,
        ALG_ACCURATE = 2'd3
    } t_alg;

    typedef enum logic [1:0] {
        CFG_ALGORITHM = 2'd0,
        CFG_PORTRAIT  = 2'd1,
        CFG_REACH     = 2'd2,
        CFG_ENABLE    = 2'd3
    } t_cfg_idx;

    localparam int TBGM_BUTTON_SIZE = 160;
    localparam int TBGM_COORD_BITS  = 13;

    localparam int GRID_DIM    = 4;
    localparam int NUM_BUTTONS = GRID_DIM * GRID_DIM;
    localparam int IDX_BITS    = 4;

    localparam int GAP_OUTER  = 37;
    localparam int GAP_MIDDLE = 38;
    localparam int GAP_SUM [GRID_DIM] = '{0, GAP_OUTER, GAP_OUTER + GAP_MIDDLE,
                                          GAP_OUTER + GAP_MIDDLE + GAP_OUTER};

    localparam int PORTRAIT_ORIGIN_X  = 8;
    localparam int PORTRAIT_ORIGIN_Y  = 602;
    localparam int LANDSCAPE_ORIGIN_X = 6;
    localparam int LANDSCAPE_ORIGIN_Y = 8;

    localparam int LEGACY_OFFSET  = 580;
    localparam int LEGACY_WIDTH   = 768;
    localparam int LEGACY_HEIGHT  = 1360 - 580;
    localparam int LEGACY_COL_DIV = LEGACY_WIDTH / GRID_DIM;
    localparam int LEGACY_ROW_DIV = LEGACY_HEIGHT / GRID_DIM;

    // Truncating quotient by reciprocal: exact for magnitudes below 2**16.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 17;
    localparam int RECIP_COL   = (2**RECIP_SHIFT + LEGACY_COL_DIV - 1) / LEGACY_COL_DIV;
    localparam int RECIP_ROW   = (2**RECIP_SHIFT + LEGACY_ROW_DIV - 1) / LEGACY_ROW_DIV;

    // Axis gaps are clamped here; its square exceeds any reach squared.
    localparam int GAP_CAP  = 64;
    localparam int GAP_W    = 7;
    localparam int SQ_W     = 13;
    localparam int DIST_W   = 14;
    localparam int REACH_W  = 6;
    localparam int LIM_W    = 12;

    localparam int ALG_RESET   = 1;
    localparam int REACH_RESET = 38;

    function automatic int edge_lo(input int origin, input int k, input int size);
        return origin + k * size + GAP_SUM[k];
    endfunction

endpackage

[hdl/touch_to_button_grid_mapper.sv]
// Touch grid mapper: maps contacts onto a 4x4 button grid and emits a mask per frame.
`timescale 1ns / 1ps

// One contact is taken per clock. A contact is held in an input register, and in the
// next cycle all sixteen button distance checks (or the legacy division by reciprocal
// multiply) run side by side and the hits are ORed into the frame mask. An item that
// carries the frame-end mark loads the mask into the output register, which holds the
// result until it is taken. The input register keeps taking items
// while a result waits, and stalls only when a frame end meets a full output register.
// Configuration writes take effect at once and are meant for an idle block.
module touch_to_button_grid_mapper import tbgm_pkg::*; #(
    parameter int BUTTON_SIZE = TBGM_BUTTON_SIZE,
    parameter int COORD_BITS  = TBGM_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [REACH_W-1:0]           i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    input  logic                         i_has_contact,
    input  logic                         i_frame_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [NUM_BUTTONS-1:0]       o_button_mask
);

    localparam int AX_W   = COORD_BITS + 3;
    localparam int MAG_W  = COORD_BITS + 1;
    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int LIDX_W = Q_W + 3;
    localparam int KEY_W  = DIST_W + 1;

    // configuration
    t_alg               r_alg, n_alg;
    logic               r_portrait, n_portrait;
    logic [LIM_W-1:0]   r_reach_sq, n_reach_sq;
    logic               r_enable, n_enable;

    // input stage
    logic                         r_in_valid, n_in_valid;
    logic signed [COORD_BITS-1:0] r_in_x;
    logic signed [COORD_BITS-1:0] r_in_y;
    logic                         r_in_contact;
    logic                         r_in_end;

    // frame and output
    logic [NUM_BUTTONS-1:0] r_frame, n_frame;
    logic                   r_out_valid, n_out_valid;
    logic [NUM_BUTTONS-1:0] r_out_mask, n_out_mask;

    logic                   w_advance;
    logic                   w_load;
    logic [NUM_BUTTONS-1:0] w_hit;
    logic [NUM_BUTTONS-1:0] w_accum;

    // legacy path
    logic signed [MAG_W-1:0]  w_lx_s, w_ly_s;
    logic [MAG_W-1:0]         w_lx_mag, w_ly_mag;
    logic [PROD_W-1:0]        w_lx_prod, w_ly_prod;
    logic [Q_W-1:0]           w_lx_q, w_ly_q;
    logic signed [LIDX_W-1:0] w_col, w_row, w_lidx;
    logic [NUM_BUTTONS-1:0]   w_legacy_hit;

    // grid path
    logic signed [AX_W-1:0] w_px, w_py;
    logic [GAP_W-1:0]       w_gx [GRID_DIM];
    logic [GAP_W-1:0]       w_gy [GRID_DIM];
    logic [SQ_W-1:0]        w_sqx [GRID_DIM];
    logic [SQ_W-1:0]        w_sqy [GRID_DIM];
    logic [LIM_W-1:0]       w_lim;
    logic [NUM_BUTTONS-1:0] w_within;
    logic [KEY_W-1:0]       w_key [NUM_BUTTONS];
    logic [KEY_W-1:0]       w_k1 [8];
    logic [IDX_BITS-1:0]    w_i1 [8];
    logic [KEY_W-1:0]       w_k2 [4];
    logic [IDX_BITS-1:0]    w_i2 [4];
    logic [KEY_W-1:0]       w_k3 [2];
    logic [IDX_BITS-1:0]    w_i3 [2];
    logic [KEY_W-1:0]       w_k4;
    logic [IDX_BITS-1:0]    w_i4;
    logic [NUM_BUTTONS-1:0] w_best_hit;

    // handshake
    assign w_advance = r_in_valid && (!r_in_end || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_load    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_button_mask = r_out_mask;

    // configuration writes
    always_comb begin
        n_alg      = r_alg;
        n_portrait = r_portrait;
        n_reach_sq = r_reach_sq;
        n_enable   = r_enable;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALGORITHM: n_alg      = t_alg'(i_cfg_data[1:0]);
                CFG_PORTRAIT:  n_portrait = i_cfg_data[0];
                CFG_REACH:     n_reach_sq = {{(LIM_W-REACH_W){1'b0}}, i_cfg_data}
                                          * {{(LIM_W-REACH_W){1'b0}}, i_cfg_data};
                CFG_ENABLE:    n_enable   = i_cfg_data[0];
                default:       n_enable   = r_enable;
            endcase
        end
    end

    // legacy even division
    always_comb begin
        w_lx_s   = MAG_W'(r_in_x);
        w_ly_s   = MAG_W'(r_in_y) - (r_portrait ? MAG_W'(LEGACY_OFFSET) : '0);
        w_lx_mag = w_lx_s[MAG_W-1] ? MAG_W'(-w_lx_s) : MAG_W'(w_lx_s);
        w_ly_mag = w_ly_s[MAG_W-1] ? MAG_W'(-w_ly_s) : MAG_W'(w_ly_s);
        w_lx_prod = PROD_W'(w_lx_mag) * PROD_W'(RECIP_COL);
        w_ly_prod = PROD_W'(w_ly_mag) * PROD_W'(RECIP_ROW);
        w_lx_q = w_lx_prod[PROD_W-1:RECIP_SHIFT];
        w_ly_q = w_ly_prod[PROD_W-1:RECIP_SHIFT];
        w_col  = w_lx_s[MAG_W-1] ? -LIDX_W'(w_lx_q) : LIDX_W'(w_lx_q);
        w_row  = w_ly_s[MAG_W-1] ? -LIDX_W'(w_ly_q) : LIDX_W'(w_ly_q);
        w_lidx = {w_row[LIDX_W-3:0], 2'b00} + w_col;
        if (!w_lidx[LIDX_W-1] && w_lidx < LIDX_W'(NUM_BUTTONS)) begin
            w_legacy_hit = NUM_BUTTONS'(1) << w_lidx[IDX_BITS-1:0];
        end else begin
            w_legacy_hit = '0;
        end
    end

    // per-axis distance to each button column and row
    assign w_px = AX_W'(r_in_x);
    assign w_py = AX_W'(r_in_y);

    for (genvar k = 0; k < GRID_DIM; k++) begin : g_axis
        localparam int LO_XP = edge_lo(PORTRAIT_ORIGIN_X, k, BUTTON_SIZE);
        localparam int LO_XL = edge_lo(LANDSCAPE_ORIGIN_X, k, BUTTON_SIZE);
        localparam int LO_YP = edge_lo(PORTRAIT_ORIGIN_Y, k, BUTTON_SIZE);
        localparam int LO_YL = edge_lo(LANDSCAPE_ORIGIN_Y, k, BUTTON_SIZE);

        logic signed [AX_W-1:0] w_xlo, w_ylo, w_xdlo, w_xdhi, w_ydlo, w_ydhi;
        logic signed [AX_W-1:0] w_xd, w_yd;

        always_comb begin
            w_xlo  = r_portrait ? AX_W'(LO_XP) : AX_W'(LO_XL);
            w_ylo  = r_portrait ? AX_W'(LO_YP) : AX_W'(LO_YL);
            w_xdlo = w_xlo - w_px;
            w_xdhi = w_px - (w_xlo + AX_W'(BUTTON_SIZE - 1));
            w_ydlo = w_ylo - w_py;
            w_ydhi = w_py - (w_ylo + AX_W'(BUTTON_SIZE - 1));
            if (!w_xdlo[AX_W-1] && w_xdlo != '0) begin
                w_xd = w_xdlo;
            end else if (!w_xdhi[AX_W-1] && w_xdhi != '0) begin
                w_xd = w_xdhi;
            end else begin
                w_xd = '0;
            end
            if (!w_ydlo[AX_W-1] && w_ydlo != '0) begin
                w_yd = w_ydlo;
            end else if (!w_ydhi[AX_W-1] && w_ydhi != '0) begin
                w_yd = w_ydhi;
            end else begin
                w_yd = '0;
            end
            w_gx[k]  = (w_xd > AX_W'(GAP_CAP)) ? GAP_W'(GAP_CAP) : w_xd[GAP_W-1:0];
            w_gy[k]  = (w_yd > AX_W'(GAP_CAP)) ? GAP_W'(GAP_CAP) : w_yd[GAP_W-1:0];
            w_sqx[k] = SQ_W'(w_gx[k]) * SQ_W'(w_gx[k]);
            w_sqy[k] = SQ_W'(w_gy[k]) * SQ_W'(w_gy[k]);
        end
    end

    // reach test and nearest search
    assign w_lim = (r_alg == ALG_ACCURATE) ? '0 : r_reach_sq;

    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            w_key[b][DIST_W-1:0] = DIST_W'(w_sqx[b % GRID_DIM])
                                 + DIST_W'(w_sqy[b / GRID_DIM]);
            w_within[b]          = w_key[b][DIST_W-1:0] <= DIST_W'(w_lim);
            w_key[b][DIST_W]     = !w_within[b];
        end
        for (int i = 0; i < 8; i++) begin
            if (w_key[2*i+1] < w_key[2*i]) begin
                w_k1[i] = w_key[2*i+1];
                w_i1[i] = IDX_BITS'(2*i+1);
            end else begin
                w_k1[i] = w_key[2*i];
                w_i1[i] = IDX_BITS'(2*i);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (w_k1[2*i+1] < w_k1[2*i]) begin
                w_k2[i] = w_k1[2*i+1];
                w_i2[i] = w_i1[2*i+1];
            end else begin
                w_k2[i] = w_k1[2*i];
                w_i2[i] = w_i1[2*i];
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (w_k2[2*i+1] < w_k2[2*i]) begin
                w_k3[i] = w_k2[2*i+1];
                w_i3[i] = w_i2[2*i+1];
            end else begin
                w_k3[i] = w_k2[2*i];
                w_i3[i] = w_i2[2*i];
            end
        end
        if (w_k3[1] < w_k3[0]) begin
            w_k4 = w_k3[1];
            w_i4 = w_i3[1];
        end else begin
            w_k4 = w_k3[0];
            w_i4 = w_i3[0];
        end
        w_best_hit = w_k4[DIST_W] ? '0 : (NUM_BUTTONS'(1) << w_i4);
    end

    always_comb begin
        case (r_alg)
            ALG_LEGACY: w_hit = w_legacy_hit;
            ALG_PLUS:   w_hit = w_within;
            default:    w_hit = w_best_hit;
        endcase
    end

    // frame accumulation and result register
    assign w_accum = (r_in_contact && r_enable) ? (r_frame | w_hit) : r_frame;

    always_comb begin
        n_in_valid  = o_ready ? i_valid : r_in_valid;
        n_frame     = r_frame;
        n_out_valid = r_out_valid;
        n_out_mask  = r_out_mask;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_advance) begin
            if (r_in_end) begin
                n_frame     = '0;
                n_out_valid = 1'b1;
                n_out_mask  = r_enable ? w_accum : '0;
            end else begin
                n_frame = w_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg       <= t_alg'(ALG_RESET);
            r_portrait  <= 1'b1;
            r_reach_sq  <= LIM_W'(REACH_RESET * REACH_RESET);
            r_enable    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_alg       <= n_alg;
            r_portrait  <= n_portrait;
            r_reach_sq  <= n_reach_sq;
            r_enable    <= n_enable;
            r_in_valid  <= n_in_valid;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_x       <= i_x_coord;
            r_in_y       <= i_y_coord;
            r_in_contact <= i_has_contact;
            r_in_end     <= i_frame_end;
        end
        r_out_mask <= n_out_mask;
    end

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_end) |=> (r_frame == '0))
        else $error("frame mask not cleared after frame end");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_enable) |-> (o_button_mask == '0))
        else $error("nonzero mask emitted while disabled");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_alg != ALG_PLUS) |-> $onehot0(w_hit))
        else $error("more than one button hit outside plus mode");

endmodule
